// ===== hdl/hbbc_pkg.sv =====
// ----------------------------------------------------------------------------
// hbbc_pkg
// shared types and constants of the hashed block buffer cache
// ----------------------------------------------------------------------------
package hbbc_pkg;

    localparam int BUFFER_COUNT = 30;
    localparam int BUCKET_COUNT = 13;
    localparam int ADDR_W       = $clog2(BUFFER_COUNT);
    localparam int BUCKET_W     = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int BLOCK_W      = 32;
    localparam int DEVICE_W     = 8;
    localparam int COUNT_W      = 8;
    localparam int SLOT_W       = 6;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    typedef enum logic [1:0] {
        OP_GET     = 2'd0,
        OP_RELEASE = 2'd1,
        OP_PIN     = 2'd2,
        OP_UNPIN   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    typedef struct packed {
        logic [DEVICE_W-1:0] device;
        logic [BLOCK_W-1:0]  block;
        logic                valid;
        logic [COUNT_W-1:0]  count;
        logic [BUCKET_W-1:0] bucket;
        logic [ADDR_W-1:0]   rank;
    } t_entry;

endpackage

// ===== hdl/hashed_block_buffer_cache.sv =====
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache
// tag store for a hashed pool of block buffers with reference counts and lru
// ----------------------------------------------------------------------------
// One item is worked at a time and every item gives one result transfer.
// After reset a clearing pass writes the reset tags, buckets and ranks into
// every slot of the tag memory; no item is taken meanwhile.
// Release, pin and unpin read the slot at accept and write it back (one
// memory read, at most one write); a slot out of range goes straight to the
// result. A get hashes the block number (one byte per cycle), then sweeps the
// tag memory for the lookup and the victim search, decides and hands over the
// result. A miss that retags a buffer adds a second sweep over the tag memory
// that renumbers the recency ranks. A release that drops a count to zero
// takes the hash and the rank sweep. A result still stalled in the output
// register holds the next one back. The tag memory has a single read port,
// so each sweep reads the slots one after another.
// ----------------------------------------------------------------------------
module hashed_block_buffer_cache (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_device_id,
    input  logic [31:0] i_block_number,
    input  logic [5:0]  i_buffer_slot,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_slot_index,
    output logic        o_was_hit,
    output logic        o_needs_read,
    output logic [1:0]  o_status
);

    localparam int AW = hbbc_pkg::ADDR_W;
    localparam int N  = hbbc_pkg::BUFFER_COUNT;

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_HASH   = 8'b0000_0100,
        S_SCAN   = 8'b0000_1000,
        S_DECIDE = 8'b0001_0000,
        S_OPEX   = 8'b0010_0000,
        S_SWEEP  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // memory port signals
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;
    hbbc_pkg::t_entry       mem_rdata;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    hbbc_pkg::t_entry       mem_wdata;

    // hash unit
    logic                          hash_start;
    logic [31:0]                   hash_value;
    logic                          hash_done;
    logic [hbbc_pkg::BUCKET_W-1:0] hash_rem;

    // sweep pointer and read pipeline
    logic [AW:0]   r_ptr;
    logic          r_pend;
    logic [AW-1:0] r_pidx;
    logic          issue;
    logic          last_data;
    logic [hbbc_pkg::BUCKET_W-1:0] r_init_bkt;

    // request latch
    logic [1:0]  r_op;
    logic [7:0]  r_dev;
    logic [31:0] r_blk;
    logic [5:0]  r_slot;
    logic [hbbc_pkg::BUCKET_W-1:0] r_hash;

    // lookup and victim search results
    logic                   r_hit_f;
    logic [AW-1:0]          r_hit_idx;
    hbbc_pkg::t_entry       r_hit_rec;
    logic                   r_vic_f;
    logic [AW-1:0]          r_vic_idx;
    logic [hbbc_pkg::BUCKET_W+AW-1:0] r_vic_key;

    // target of the rank sweep
    logic [AW-1:0]          r_tgt;
    logic [AW-1:0]          r_tgt_rank;
    hbbc_pkg::t_entry       r_tgt_rec;

    // pending result and output register
    logic [5:0] r_res_slot;
    logic       r_res_hit;
    logic       r_res_rd;
    logic [1:0] r_res_st;
    logic       r_out_valid;
    logic [5:0] r_out_slot;
    logic       r_out_hit;
    logic       r_out_rd;
    logic [1:0] r_out_st;

    logic in_xfer;
    logic out_free;
    logic slot_oor;
    logic scan_match;
    logic scan_better;
    logic scan_free;
    logic [hbbc_pkg::BUCKET_W+AW-1:0] scan_key;
    hbbc_pkg::t_entry hit_wr;
    hbbc_pkg::t_entry op_wr;
    hbbc_pkg::t_entry sweep_wr;
    hbbc_pkg::t_entry init_wr;

    hbbc_tag_ram u_ram (
        .i_clk   (i_clk),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata)
    );

    hbbc_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_value (hash_value),
        .o_done  (hash_done),
        .o_rem   (hash_rem)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign slot_oor   = {1'b0, i_buffer_slot} >= 7'(N);

    // reads are issued for every slot in turn during scan and sweep
    assign issue     = ((r_state == S_SCAN) || (r_state == S_SWEEP)) && (r_ptr < (AW+1)'(N));
    assign last_data = r_pend && (r_pidx == AW'(N - 1));

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_ptr[AW-1:0];
        if (issue) begin
            mem_re = 1'b1;
        end else if (in_xfer && (i_operation != hbbc_pkg::OP_GET) && !slot_oor) begin
            mem_re    = 1'b1;
            mem_raddr = i_buffer_slot[AW-1:0];
        end
    end

    // hash start: get at accept, release to zero from the stored tag
    always_comb begin
        hash_start = 1'b0;
        hash_value = i_block_number;
        if (in_xfer && (i_operation == hbbc_pkg::OP_GET)) begin
            hash_start = 1'b1;
        end else if (r_state == S_OPEX && r_op == hbbc_pkg::OP_RELEASE
                     && mem_rdata.count == 8'd1) begin
            hash_start = 1'b1;
            hash_value = mem_rdata.block;
        end
    end

    // lookup: most recent matching tag in the hashed bucket
    // victim: free buffer with smallest bucket, then smallest rank
    always_comb begin
        scan_match  = (mem_rdata.bucket == r_hash) && (mem_rdata.device == r_dev)
                      && (mem_rdata.block == r_blk);
        scan_better = !r_hit_f || (mem_rdata.rank > r_hit_rec.rank);
        scan_free   = (mem_rdata.count == '0);
        scan_key    = {mem_rdata.bucket, mem_rdata.rank};
    end

    // write data for each case
    always_comb begin
        hit_wr       = r_hit_rec;
        hit_wr.valid = 1'b1;
        if (r_hit_rec.count != hbbc_pkg::COUNT_MAX) begin
            hit_wr.count = r_hit_rec.count + 1'b1;
        end

        op_wr = mem_rdata;
        if (r_op == hbbc_pkg::OP_PIN) begin
            op_wr.count = mem_rdata.count + 1'b1;
        end else begin
            op_wr.count = mem_rdata.count - 1'b1;
        end

        sweep_wr = mem_rdata;
        if (r_pidx == r_tgt) begin
            sweep_wr = r_tgt_rec;
        end else if (mem_rdata.rank > r_tgt_rank) begin
            sweep_wr.rank = mem_rdata.rank - 1'b1;
        end

        init_wr        = '0;
        init_wr.bucket = r_init_bkt;
        init_wr.rank   = r_ptr[AW-1:0];
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_pidx;
        mem_wdata = sweep_wr;
        unique case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr[AW-1:0];
                mem_wdata = init_wr;
            end
            S_DECIDE: begin
                mem_we    = r_hit_f;
                mem_waddr = r_hit_idx;
                mem_wdata = hit_wr;
            end
            S_OPEX: begin
                mem_waddr = r_slot[AW-1:0];
                mem_wdata = op_wr;
                if (r_op == hbbc_pkg::OP_PIN) begin
                    mem_we = (mem_rdata.count != hbbc_pkg::COUNT_MAX);
                end else begin
                    mem_we = (mem_rdata.count != '0);
                end
            end
            S_SWEEP: begin
                mem_we = r_pend;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (r_ptr == (AW+1)'(N - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_operation == hbbc_pkg::OP_GET) begin
                        n_state = S_HASH;
                    end else if (slot_oor) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_OPEX;
                    end
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_state = (r_op == hbbc_pkg::OP_GET) ? S_SCAN : S_SWEEP;
                end
            end
            S_SCAN: begin
                if (last_data) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = (!r_hit_f && r_vic_f) ? S_SWEEP : S_DONE;
            end
            S_OPEX: begin
                if (r_op == hbbc_pkg::OP_RELEASE && mem_rdata.count == 8'd1) begin
                    n_state = S_HASH;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SWEEP: begin
                if (last_data) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_ptr       <= '0;
            r_pend      <= 1'b0;
            r_init_bkt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= issue;
            // pointer: clearing pass, then reused by scan and sweep
            if (r_state == S_INIT) begin
                if (n_state != S_INIT) begin
                    r_ptr <= '0;
                end else begin
                    r_ptr <= r_ptr + 1'b1;
                end
                if (r_init_bkt == hbbc_pkg::BUCKET_W'(hbbc_pkg::BUCKET_COUNT - 1)) begin
                    r_init_bkt <= '0;
                end else begin
                    r_init_bkt <= r_init_bkt + 1'b1;
                end
            end else if (issue) begin
                r_ptr <= r_ptr + 1'b1;
            end else if (n_state == S_SCAN || n_state == S_SWEEP) begin
                if (r_state != S_SCAN && r_state != S_SWEEP) begin
                    r_ptr <= '0;
                end
            end else if (r_state == S_SCAN && n_state == S_DECIDE) begin
                r_ptr <= '0;
            end
            // output register, loaded while the previous transfer drains
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pidx <= r_ptr[AW-1:0];
        if (in_xfer) begin
            r_op       <= i_operation;
            r_dev      <= i_device_id;
            r_blk      <= i_block_number;
            r_slot     <= i_buffer_slot;
            r_hit_f    <= 1'b0;
            r_vic_f    <= 1'b0;
            r_res_slot <= i_buffer_slot;
            r_res_hit  <= 1'b0;
            r_res_rd   <= 1'b0;
            r_res_st   <= hbbc_pkg::ST_OK;
        end
        if (r_state == S_HASH && hash_done) begin
            r_hash           <= hash_rem;
            r_tgt_rec.bucket <= hash_rem;
        end
        if (r_state == S_SCAN && r_pend) begin
            if (scan_match && scan_better) begin
                r_hit_f   <= 1'b1;
                r_hit_idx <= r_pidx;
                r_hit_rec <= mem_rdata;
            end
            if (scan_free && (!r_vic_f || scan_key < r_vic_key)) begin
                r_vic_f   <= 1'b1;
                r_vic_idx <= r_pidx;
                r_vic_key <= scan_key;
            end
        end
        if (r_state == S_DECIDE) begin
            if (r_hit_f) begin
                r_res_slot <= 6'(r_hit_idx);
                r_res_hit  <= 1'b1;
                r_res_rd   <= !r_hit_rec.valid;
                r_res_st   <= (r_hit_rec.count == hbbc_pkg::COUNT_MAX)
                              ? hbbc_pkg::ST_OVERFLOW : hbbc_pkg::ST_OK;
            end else if (!r_vic_f) begin
                r_res_slot <= '0;
                r_res_st   <= hbbc_pkg::ST_NO_FREE;
            end else begin
                // retag the victim as most recent in the hashed bucket
                r_res_slot <= 6'(r_vic_idx);
                r_res_rd   <= 1'b1;
                r_tgt      <= r_vic_idx;
                r_tgt_rank <= r_vic_key[AW-1:0];
                r_tgt_rec  <= '{device: r_dev, block: r_blk, valid: 1'b1,
                                count: 8'd1, bucket: r_hash, rank: AW'(N - 1)};
            end
        end
        if (r_state == S_OPEX) begin
            if (r_op == hbbc_pkg::OP_PIN) begin
                if (mem_rdata.count == hbbc_pkg::COUNT_MAX) begin
                    r_res_st <= hbbc_pkg::ST_OVERFLOW;
                end
            end else if (mem_rdata.count == '0) begin
                r_res_st <= hbbc_pkg::ST_UNDERFLOW;
            end
            // release to zero: bucket follows once the hash is done
            r_tgt      <= r_slot[AW-1:0];
            r_tgt_rank <= mem_rdata.rank;
            r_tgt_rec  <= '{device: mem_rdata.device, block: mem_rdata.block,
                            valid: mem_rdata.valid, count: '0,
                            bucket: mem_rdata.bucket, rank: AW'(N - 1)};
        end
        if (r_state == S_DONE && out_free) begin
            r_out_slot <= r_res_slot;
            r_out_hit  <= r_res_hit;
            r_out_rd   <= r_res_rd;
            r_out_st   <= r_res_st;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_slot_index = r_out_slot;
    assign o_was_hit    = r_out_hit;
    assign o_needs_read = r_out_rd;
    assign o_status     = r_out_st;

endmodule

// ===== hdl/hbbc_tag_ram.sv =====
// ----------------------------------------------------------------------------
// hbbc_tag_ram
// per-buffer tag memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module hbbc_tag_ram (
    input  logic                       i_clk,
    input  logic                       i_re,
    input  logic [hbbc_pkg::ADDR_W-1:0] i_raddr,
    output hbbc_pkg::t_entry           o_rdata,
    input  logic                       i_we,
    input  logic [hbbc_pkg::ADDR_W-1:0] i_waddr,
    input  hbbc_pkg::t_entry           i_wdata
);

    hbbc_pkg::t_entry r_mem [hbbc_pkg::BUFFER_COUNT];
    hbbc_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/hbbc_mod_unit.sv =====
// ----------------------------------------------------------------------------
// hbbc_mod_unit
// block number modulo bucket count, one byte per cycle from constant tables
// ----------------------------------------------------------------------------
module hbbc_mod_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [hbbc_pkg::BLOCK_W-1:0]  i_value,
    output logic                         o_done,
    output logic [hbbc_pkg::BUCKET_W-1:0] o_rem
);

    localparam int BW    = hbbc_pkg::BUCKET_W;
    localparam int B     = hbbc_pkg::BUCKET_COUNT;
    localparam int STEPS = hbbc_pkg::BLOCK_W / 8;
    localparam int CNT_W = $clog2(STEPS);

    logic [hbbc_pkg::BLOCK_W-1:0]  r_sh;
    logic [BW-1:0]                 r_rem;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [BW:0]                   n_sum;
    logic [BW-1:0]                 n_rem;

    // residue tables: (r * 256) mod B and byte mod B
    logic [BW-1:0] c_hi [2**BW];
    logic [BW-1:0] c_lo [256];

    for (genvar g = 0; g < 2**BW; g++) begin : g_hi
        assign c_hi[g] = BW'((g * 256) % B);
    end

    for (genvar g = 0; g < 256; g++) begin : g_lo
        assign c_lo[g] = BW'(g % B);
    end

    // both terms are below the divisor, one subtract brings the sum back
    always_comb begin
        n_sum = {1'b0, c_hi[r_rem]} + {1'b0, c_lo[r_sh[hbbc_pkg::BLOCK_W-1 -: 8]]};
        if (n_sum >= (BW+1)'(B)) begin
            n_rem = BW'(n_sum - (BW+1)'(B));
        end else begin
            n_rem = BW'(n_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_sh   <= i_value;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_sh  <= r_sh << 8;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
